// ----- rtl/core/atds_pkg.sv -----
// Shared constants, types and register codes for the averaged target deadband steer block.
package atds_pkg;

  localparam int DEPTH  = 11;
  localparam int FLD_W  = 18;
  localparam int LIM_W  = 17;
  localparam int SPD_W  = 12;
  localparam int VEL_W  = 13;
  localparam int CIDX_W = 3;
  localparam int LANES  = 3;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = FLD_W + $clog2(DEPTH);
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int FIX_W  = FLD_W + 1;

  localparam logic [LIM_W-1:0] FRONT_RST  = LIM_W'(5800);
  localparam logic [LIM_W-1:0] REAR_RST   = LIM_W'(4500);
  localparam logic [LIM_W-1:0] BAND_RST   = LIM_W'(100);
  localparam logic [LIM_W-1:0] STOP_RST   = LIM_W'(50);
  localparam logic [FLD_W-1:0] XOFF_RST   = FLD_W'(1500);
  localparam logic [FLD_W-1:0] ZOFF_RST   = FLD_W'(760);
  localparam logic [SPD_W-1:0] SPEED_RST  = SPD_W'(200);

  typedef enum logic [CIDX_W-1:0] {
    CFG_FRONT = 3'd0,
    CFG_REAR  = 3'd1,
    CFG_BAND  = 3'd2,
    CFG_STOP  = 3'd3,
    CFG_XOFF  = 3'd4,
    CFG_ZOFF  = 3'd5,
    CFG_SPEED = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic load_in;
    logic read_old;
    logic update;
    logic div_load;
    logic div_step;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/core/atds_if.sv -----
// Channel interfaces: camera point input, steer result output and configuration writes.
interface atds_point_if;
  logic                      valid;
  logic                      ready;
  logic signed [atds_pkg::FLD_W-1:0] cam_x;
  logic signed [atds_pkg::FLD_W-1:0] cam_y;
  logic signed [atds_pkg::FLD_W-1:0] cam_z;
  modport source (output valid, cam_x, cam_y, cam_z, input ready);
  modport sink (input valid, cam_x, cam_y, cam_z, output ready);
endinterface

interface atds_result_if;
  logic                      valid;
  logic                      ready;
  logic signed [atds_pkg::FLD_W-1:0] pos_x;
  logic signed [atds_pkg::FLD_W-1:0] pos_y;
  logic signed [atds_pkg::FLD_W-1:0] pos_z;
  logic signed [atds_pkg::VEL_W-1:0] vel_forward;
  logic signed [atds_pkg::VEL_W-1:0] vel_lateral;
  logic                      aligned;
  modport source (output valid, pos_x, pos_y, pos_z, vel_forward, vel_lateral, aligned,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_forward, vel_lateral, aligned,
                output ready);
endinterface

interface atds_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [atds_pkg::CIDX_W-1:0] index;
  logic [atds_pkg::FLD_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/atds_ctrl.sv -----
// Sequencer for window update, serial divide and deadband decision.
module atds_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_ready,
  input  atds_pkg::stat_t stat,
  output atds_pkg::cmd_t  cmd
);
  import atds_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_LOAD   = 6'b001000,
    S_DIV    = 6'b010000,
    S_DECIDE = 6'b100000
  } state_t;

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      S_IDLE:   if (point_valid) state_next = S_READ;
      S_READ:   state_next = S_UPDATE;
      S_UPDATE: state_next = S_LOAD;
      S_LOAD: begin
        step_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(SUM_W - 1)) state_next = S_DECIDE;
      end
      S_DECIDE: if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign point_ready  = (state == S_IDLE);
  assign cmd.load_in  = (state == S_IDLE) && point_valid;
  assign cmd.read_old = (state == S_READ);
  assign cmd.update   = (state == S_UPDATE);
  assign cmd.div_load = (state == S_LOAD);
  assign cmd.div_step = (state == S_DIV);
  assign cmd.decide   = (state == S_DECIDE) && stat.out_free;

endmodule

// ----- rtl/core/atds_dp.sv -----
// Datapath: config registers, sample window, running sums, divider lanes and output register.
module atds_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [atds_pkg::FLD_W-1:0] cam_x,
  input  logic signed [atds_pkg::FLD_W-1:0] cam_y,
  input  logic signed [atds_pkg::FLD_W-1:0] cam_z,
  input  atds_pkg::cmd_t                    cmd,
  output atds_pkg::stat_t                   stat,
  atds_cfg_if.sink                          cfg,
  atds_result_if.source                     result
);
  import atds_pkg::*;

  logic [LIM_W-1:0] front_limit, rear_limit, lateral_band, stop_band;
  logic [FLD_W-1:0] x_offset, z_offset;
  logic [SPD_W-1:0] speed;

  logic [LANES*FLD_W-1:0] window [DEPTH];
  logic [LANES*FLD_W-1:0] new_word, old_word;

  logic signed [SUM_W-1:0] sum [LANES];
  logic [SUM_W-1:0]        dq  [LANES];
  logic [CNT_W-1:0]        rem [LANES];
  logic                    neg [LANES];
  logic signed [FLD_W-1:0] avg [LANES];

  logic [CNT_W-1:0]  fill_count;
  logic [SLOT_W-1:0] oldest_slot, slot;
  logic              full;

  logic signed [VEL_W-1:0] held_forward, held_lateral, fwd_next, lat_next;
  logic signed [FIX_W-1:0] fx, fz, front_s, rear_s, band_s, stop_s;
  logic signed [VEL_W-1:0] spd_s;
  logic                    fwd_mid, stop_zone;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_limit  <= FRONT_RST;
      rear_limit   <= REAR_RST;
      lateral_band <= BAND_RST;
      stop_band    <= STOP_RST;
      x_offset     <= XOFF_RST;
      z_offset     <= ZOFF_RST;
      speed        <= SPEED_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_FRONT: front_limit  <= cfg.data[LIM_W-1:0];
        CFG_REAR:  rear_limit   <= cfg.data[LIM_W-1:0];
        CFG_BAND:  lateral_band <= cfg.data[LIM_W-1:0];
        CFG_STOP:  stop_band    <= cfg.data[LIM_W-1:0];
        CFG_XOFF:  x_offset     <= cfg.data;
        CFG_ZOFF:  z_offset     <= cfg.data;
        CFG_SPEED: speed        <= cfg.data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign full = (fill_count == CNT_W'(DEPTH));
  assign slot = full ? oldest_slot : fill_count[SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_in) new_word <= {cam_x, cam_y, cam_z};
    if (cmd.read_old) old_word <= window[slot];
    if (cmd.update) window[slot] <= new_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      oldest_slot <= '0;
      for (int i = 0; i < LANES; i++) sum[i] <= '0;
    end else if (cmd.update) begin
      for (int i = 0; i < LANES; i++) begin
        sum[i] <= sum[i]
                + SUM_W'($signed(new_word[(LANES-1-i)*FLD_W +: FLD_W]))
                - (full ? SUM_W'($signed(old_word[(LANES-1-i)*FLD_W +: FLD_W])) : '0);
      end
      if (full) begin
        oldest_slot <= (oldest_slot == SLOT_W'(DEPTH - 1)) ? '0 : oldest_slot + SLOT_W'(1);
      end else begin
        fill_count <= fill_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      logic [CNT_W:0] rem_sh;
      rem_sh = {rem[i], dq[i][SUM_W-1]};
      if (cmd.div_load) begin
        neg[i] <= sum[i][SUM_W-1];
        dq[i]  <= sum[i][SUM_W-1] ? SUM_W'(-sum[i]) : SUM_W'(sum[i]);
        rem[i] <= '0;
      end else if (cmd.div_step) begin
        if (rem_sh >= {1'b0, fill_count}) begin
          rem[i] <= CNT_W'(rem_sh - {1'b0, fill_count});
          dq[i]  <= {dq[i][SUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= rem_sh[CNT_W-1:0];
          dq[i]  <= {dq[i][SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      avg[i] = neg[i] ? FLD_W'(-dq[i]) : FLD_W'(dq[i]);
    end
  end

  assign fx      = FIX_W'(avg[0]) - FIX_W'($signed(x_offset));
  assign fz      = FIX_W'(avg[2]) - FIX_W'($signed(z_offset));
  assign front_s = $signed(FIX_W'(front_limit));
  assign rear_s  = $signed(FIX_W'(rear_limit));
  assign band_s  = $signed(FIX_W'(lateral_band));
  assign stop_s  = $signed(FIX_W'(stop_band));
  assign spd_s   = $signed(VEL_W'(speed));

  assign fwd_mid   = (fx > rear_s) && (fx < front_s);
  assign stop_zone = fwd_mid && (fz > -stop_s) && (fz < stop_s);

  always_comb begin
    fwd_next = held_forward;
    lat_next = held_lateral;
    if (fx > front_s) fwd_next = spd_s;
    if (fx < rear_s) fwd_next = -spd_s;
    if (fz > band_s) lat_next = -spd_s;
    if (fz < -band_s) lat_next = spd_s;
    if ((fz > -band_s) && (fz < band_s)) lat_next = '0;
    if (fwd_mid) fwd_next = '0;
    if (stop_zone) lat_next = '0;
  end

  function automatic logic signed [FLD_W-1:0] sat(input logic signed [FIX_W-1:0] v);
    logic signed [FLD_W-1:0] r;
    if (v[FIX_W-1] == v[FIX_W-2]) r = v[FLD_W-1:0];
    else if (v[FIX_W-1]) r = {1'b1, {(FLD_W-1){1'b0}}};
    else r = {1'b0, {(FLD_W-1){1'b1}}};
    return r;
  endfunction

  assign stat.out_free = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      held_forward <= '0;
      held_lateral <= '0;
    end else if (cmd.decide) begin
      result.valid <= 1'b1;
      held_forward <= fwd_next;
      held_lateral <= lat_next;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      result.pos_x       <= sat(fx);
      result.pos_y       <= avg[1];
      result.pos_z       <= sat(fz);
      result.vel_forward <= fwd_next;
      result.vel_lateral <= lat_next;
      result.aligned     <= stop_zone;
    end
  end

endmodule

// ----- rtl/core/averaged_target_deadband_steer.sv -----
// Top level of the averaged target deadband steer block.
//   channel  dir  handshake      payload
//   point    in   valid/ready    cam_x, cam_y, cam_z
//   result   out  valid/ready    pos_x, pos_y, pos_z, vel_forward, vel_lateral, aligned
//   cfg      in   valid/ready    index, data (ready always high)
// After a point transfers, a result goes valid after window read, sum update,
// divider load, one quotient bit per cycle over the 22 bit sum, then the decision.
// The next point transfers only once the previous one has passed the decision.
// Reset restores register defaults and empties the window; no clearing pass.
// A new point is taken while a result waits; the decision holds until the output
// register frees up.
module averaged_target_deadband_steer (
  input  logic         clk,
  input  logic         rst,
  atds_point_if.sink   point,
  atds_result_if.source result,
  atds_cfg_if.sink     cfg
);
  import atds_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  atds_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  atds_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cam_x  (point.cam_x),
    .cam_y  (point.cam_y),
    .cam_z  (point.cam_z),
    .cmd    (cmd),
    .stat   (stat),
    .cfg    (cfg),
    .result (result)
  );

endmodule

// ----- rtl/core/atds_checker.sv -----
// Port-level checks for the averaged target deadband steer block, with its bind.
module atds_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              point_valid,
  input logic                              point_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [atds_pkg::VEL_W-1:0] vel_forward,
  input logic signed [atds_pkg::VEL_W-1:0] vel_lateral,
  input logic                              aligned
);
  import atds_pkg::*;

  logic point_xfer;
  assign point_xfer = point_valid && point_ready;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    point_xfer |=> !point_ready)
    else $error("point taken while previous point still in work");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    point_xfer |=> !$rose(result_valid))
    else $error("result appeared right after a point transfer");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result dropped before transfer");

  a_aligned_stopped: assert property (@(posedge clk) disable iff (rst)
    (result_valid && aligned) |-> (vel_forward == '0 && vel_lateral == '0))
    else $error("aligned with nonzero velocity");

endmodule

bind averaged_target_deadband_steer atds_checker u_atds_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point.valid),
  .point_ready  (point.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .vel_forward  (result.vel_forward),
  .vel_lateral  (result.vel_lateral),
  .aligned      (result.aligned)
);

// ----- test/tb_averaged_target_deadband_steer.sv -----
// Self-checking testbench for the averaged target deadband steer block.
module tb_averaged_target_deadband_steer;
  timeunit 1ns;
  timeprecision 1ps;
  import atds_pkg::*;

  localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic signed [FLD_W-1:0] pos_x;
    logic signed [FLD_W-1:0] pos_y;
    logic signed [FLD_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_forward;
    logic signed [VEL_W-1:0] vel_lateral;
    logic                    aligned;
  } steer_t;

  class steer_scoreboard;
    logic signed [FLD_W-1:0] win_x[DEPTH];
    logic signed [FLD_W-1:0] win_y[DEPTH];
    logic signed [FLD_W-1:0] win_z[DEPTH];
    longint sum_x, sum_y, sum_z;
    int fill, oldest;
    longint held_fwd, held_lat;
    logic [LIM_W-1:0] front_lim, rear_lim, lat_band, stop_band;
    logic signed [FLD_W-1:0] x_off, z_off;
    logic [SPD_W-1:0] speed;
    steer_t due[$];
    int errors;

    function new();
      sum_x = 0; sum_y = 0; sum_z = 0;
      fill = 0; oldest = 0;
      held_fwd = 0; held_lat = 0;
      front_lim = FRONT_RST; rear_lim = REAR_RST;
      lat_band = BAND_RST; stop_band = STOP_RST;
      x_off = XOFF_RST; z_off = ZOFF_RST;
      speed = SPEED_RST;
      errors = 0;
    endfunction

    function longint sat18(longint v);
      if (v > 131071) return 131071;
      if (v < -131072) return -131072;
      return v;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [FLD_W-1:0] data);
      case (idx)
        CFG_FRONT: front_lim = data[LIM_W-1:0];
        CFG_REAR:  rear_lim  = data[LIM_W-1:0];
        CFG_BAND:  lat_band  = data[LIM_W-1:0];
        CFG_STOP:  stop_band = data[LIM_W-1:0];
        CFG_XOFF:  x_off     = data;
        CFG_ZOFF:  z_off     = data;
        CFG_SPEED: speed     = data[SPD_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_point(logic signed [FLD_W-1:0] x, logic signed [FLD_W-1:0] y,
                             logic signed [FLD_W-1:0] z);
      int slot;
      longint ax, ay, az, fx, fz, front, rear, band, stp, spd;
      bit mid, al;
      steer_t r;
      if (fill < DEPTH) begin
        slot = fill;
        fill++;
      end else begin
        slot = oldest;
        sum_x -= win_x[slot];
        sum_y -= win_y[slot];
        sum_z -= win_z[slot];
        oldest = (slot + 1) % DEPTH;
      end
      win_x[slot] = x; win_y[slot] = y; win_z[slot] = z;
      sum_x += x; sum_y += y; sum_z += z;
      ax = sum_x / fill;
      ay = sum_y / fill;
      az = sum_z / fill;
      fx = ax - x_off;
      fz = az - z_off;
      front = front_lim; rear = rear_lim;
      band = lat_band; stp = stop_band; spd = speed;
      al = 1'b0;
      if (fx > front) held_fwd = spd;
      if (fx < rear) held_fwd = -spd;
      if (fz > band) held_lat = -spd;
      if (fz < -band) held_lat = spd;
      if (fz > -band && fz < band) held_lat = 0;
      mid = (fx > rear && fx < front);
      if (mid) held_fwd = 0;
      if (fz > -stp && fz < stp && mid) begin
        held_fwd = 0;
        held_lat = 0;
        al = 1'b1;
      end
      r.pos_x = FLD_W'(sat18(fx));
      r.pos_y = FLD_W'(sat18(ay));
      r.pos_z = FLD_W'(sat18(fz));
      r.vel_forward = VEL_W'(held_fwd);
      r.vel_lateral = VEL_W'(held_lat);
      r.aligned = al;
      due = {due, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_result(steer_t got);
      steer_t exp_r;
      if (due.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      exp_r = due[0];
      due.delete(0);
      if (got.pos_x !== exp_r.pos_x)
        report($sformatf("pos_x got %0d want %0d", got.pos_x, exp_r.pos_x));
      if (got.pos_y !== exp_r.pos_y)
        report($sformatf("pos_y got %0d want %0d", got.pos_y, exp_r.pos_y));
      if (got.pos_z !== exp_r.pos_z)
        report($sformatf("pos_z got %0d want %0d", got.pos_z, exp_r.pos_z));
      if (got.vel_forward !== exp_r.vel_forward)
        report($sformatf("vel_forward got %0d want %0d", got.vel_forward,
                         exp_r.vel_forward));
      if (got.vel_lateral !== exp_r.vel_lateral)
        report($sformatf("vel_lateral got %0d want %0d", got.vel_lateral,
                         exp_r.vel_lateral));
      if (got.aligned !== exp_r.aligned)
        report($sformatf("aligned got %0b want %0b", got.aligned, exp_r.aligned));
    endtask
  endclass

  logic clk;
  logic rst;
  int send_pct;
  int stall_pct;
  int stall_hold;
  longint tgt_x, tgt_z;
  steer_t got_r;
  steer_scoreboard sb = new();

  atds_point_if  point_ch();
  atds_result_if result_ch();
  atds_cfg_if    cfg_ch();

  averaged_target_deadband_steer u_top (
    .clk    (clk),
    .rst    (rst),
    .point  (point_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("averaged_target_deadband_steer regression: fail");
    $finish;
  end

  // receiver: random stalls, plus a counted hold-off on request
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        result_ch.ready <= 1'b0;
        stall_hold--;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got_r.pos_x = result_ch.pos_x;
        got_r.pos_y = result_ch.pos_y;
        got_r.pos_z = result_ch.pos_z;
        got_r.vel_forward = result_ch.vel_forward;
        got_r.vel_lateral = result_ch.vel_lateral;
        got_r.aligned = result_ch.aligned;
        sb.check_result(got_r);
      end
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (point_ch.valid && point_ch.ready)
        sb.note_point(point_ch.cam_x, point_ch.cam_y, point_ch.cam_z);
    end
  end

  function automatic logic signed [FLD_W-1:0] clamp18(longint v);
    if (v > 131071) return FLD_W'(131071);
    if (v < -131072) return FLD_W'(-131072);
    return FLD_W'(v);
  endfunction

  function automatic longint jitter(int unsigned span);
    return longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  // hold valid across back-to-back transfers; drop it only for a gap
  task automatic send_point(input logic signed [FLD_W-1:0] x, y, z);
    if ($urandom_range(99) < send_pct) begin
      point_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_pct);
    end
    point_ch.valid <= 1'b1;
    point_ch.cam_x <= x;
    point_ch.cam_y <= y;
    point_ch.cam_z <= z;
    do @(posedge clk); while (!point_ch.ready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CIDX_W-1:0] idx, input logic [FLD_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sb.due.size() != 0);
  endtask

  task automatic set_config(input logic [FLD_W-1:0] front, rear, band, stp, xoff, zoff,
                            spd);
    point_ch.valid <= 1'b0;
    wait_drained();
    cfg_write(CFG_FRONT, front);
    cfg_write(CFG_REAR, rear);
    cfg_write(CFG_BAND, band);
    cfg_write(CFG_STOP, stp);
    cfg_write(CFG_XOFF, xoff);
    cfg_write(CFG_ZOFF, zoff);
    cfg_write(CFG_SPEED, spd);
    cfg_write(CFG_UNUSED, FLD_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic pick_target();
    longint front, rear, band, stp;
    front = sb.front_lim; rear = sb.rear_lim;
    band = sb.lat_band; stp = sb.stop_band;
    case ($urandom_range(5))
      0: tgt_x = front + 1 + $urandom_range(30);
      1: tgt_x = rear - 1 - $urandom_range(30);
      2: tgt_x = (front + rear) / 2;
      3: tgt_x = front;
      4: tgt_x = rear;
      default: tgt_x = jitter(131071);
    endcase
    tgt_x += sb.x_off;
    case ($urandom_range(7))
      0: tgt_z = 0;
      1: tgt_z = band + 1 + $urandom_range(30);
      2: tgt_z = -band - 1 - $urandom_range(30);
      3: tgt_z = stp - 1;
      4: tgt_z = 1 - stp;
      5: tgt_z = band;
      6: tgt_z = -band;
      default: tgt_z = jitter(131071);
    endcase
    tgt_z += sb.z_off;
  endtask

  // settle the window on a target, mostly near the thresholds; some raw noise
  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(11) == 0) pick_target();
      if ($urandom_range(99) < 15)
        send_point(FLD_W'($urandom), FLD_W'($urandom), FLD_W'($urandom));
      else
        send_point(clamp18(tgt_x + jitter(8)), FLD_W'($urandom),
                   clamp18(tgt_z + jitter(8)));
    end
  endtask

  initial begin
    rst = 1'b1;
    point_ch.valid = 1'b0;
    point_ch.cam_x = '0;
    point_ch.cam_y = '0;
    point_ch.cam_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_pct = 0;
    stall_pct = 0;
    stall_hold = 0;
    tgt_x = 0;
    tgt_z = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_point(FLD_W'(131071), FLD_W'(131071), FLD_W'(131071));
    send_point(FLD_W'(-131072), FLD_W'(-131072), FLD_W'(-131072));
    send_point(FLD_W'(0), FLD_W'(0), FLD_W'(0));
    send_point(18'h15555, 18'h2AAAA, 18'h15555);
    send_point(18'h2AAAA, 18'h15555, 18'h2AAAA);
    send_point(FLD_W'(-1), FLD_W'(1), FLD_W'(-1));
    repeat (14) send_point(FLD_W'(6650), FLD_W'(100), FLD_W'(760));
    send_point(FLD_W'(90000), FLD_W'(0), FLD_W'(5000));
    send_point(FLD_W'(-90000), FLD_W'(0), FLD_W'(-5000));
    pick_target();
    send_random(250);

    send_pct = 78;
    set_config(FLD_W'(3000), FLD_W'(1000), FLD_W'(200), FLD_W'(150),
               FLD_W'(-500), FLD_W'(300), FLD_W'(4095));
    pick_target();
    send_random(250);

    send_pct = 0;
    stall_pct = 78;
    set_config(FLD_W'(1000), FLD_W'(3000), FLD_W'(0), FLD_W'(0),
               FLD_W'(0), FLD_W'(0), FLD_W'(1));
    pick_target();
    send_random(250);

    send_pct = 10;
    stall_pct = 10;
    set_config(18'h3FFFF, FLD_W'(0), 18'h3FFFF, 18'h3FFFF,
               FLD_W'(-131072), FLD_W'(131071), 18'h3FFFF);
    pick_target();
    send_random(250);

    send_pct = 0;
    stall_pct = 0;
    set_config(FLD_W'(0), FLD_W'(131071), FLD_W'(0), FLD_W'(131071),
               FLD_W'(131071), FLD_W'(-131072), FLD_W'(0));
    pick_target();
    send_random(200);

    set_config(FLD_W'(5800), FLD_W'(4500), FLD_W'(100), FLD_W'(50),
               FLD_W'(1500), FLD_W'(760), FLD_W'(200));
    pick_target();
    stall_hold = 300;
    send_random(75);
    point_ch.valid <= 1'b0;
    wait_drained();
    send_random(75);

    set_config(FLD_W'(2000), FLD_W'(1990), FLD_W'(20), FLD_W'(30),
               FLD_W'(-20), FLD_W'(40), FLD_W'(1234));
    pick_target();
    for (int k = 0; k < 9; k++) begin
      case (k % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 78; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 78; end
        default: begin send_pct = 10; stall_pct = 10; end
      endcase
      send_random(50);
    end

    point_ch.valid <= 1'b0;
    stall_pct = 0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("averaged_target_deadband_steer regression: pass");
    end else begin
      $display("averaged_target_deadband_steer regression: fail");
    end
    $finish;
  end

endmodule
